// ===== hdl/ctsb_pkg.sv =====
// Shared constants, field widths and the command/status bundles of the
// Cartesian tree spine builder. No dependencies.
`default_nettype none

package ctsb_pkg;

	localparam int MAX_NODES   = 64;
	localparam int VALUE_WIDTH = 32;

	// node indices as carried in results
	localparam int IDX_W  = 6;
	// spine memory address and counters able to hold MAX_NODES itself
	localparam int ADDR_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);

	localparam int ENTRY_W = VALUE_WIDTH + ADDR_W;

	localparam int IN_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_FLD_W  = 4 * IDX_W + 2;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	// flips the sign bit so that unsigned compares give signed order
	localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

	typedef struct packed {
		logic accept;     // take the request from the slave side
		logic pop_top;    // pop the cached top entry
		logic pop_scan;   // pop the entry just read from the spine memory
		logic keep_scan;  // entry just read stays and becomes the cached top
		logic emit;       // push the new node and load the result register
	} ctsb_cmd_t;

	typedef struct packed {
		logic ovf;        // node capacity reached
		logic top_ge;     // cached top >= incoming value
		logic more;       // more than one entry on the spine
		logic scan_gt;    // entry read back > held value
		logic out_free;   // result register can take a new result
	} ctsb_status_t;

endpackage

`default_nettype wire

// ===== hdl/ctsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ctsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ctsb_ctrl.sv =====
// Sequencer of the spine builder: accept, pop scan through the spine memory,
// push and result hand-off. Depends on ctsb_pkg.
`default_nettype none

module ctsb_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire ctsb_pkg::ctsb_status_t st,
	output      ctsb_pkg::ctsb_cmd_t    cmd
);

	import ctsb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!st.ovf && st.top_ge) begin
						cmd.pop_top = 1'b1;
						state_nxt   = st.more ? ST_SCAN : ST_EMIT;
					end else begin
						state_nxt = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				// read data holds the entry below the last one popped
				if (st.scan_gt) begin
					cmd.pop_scan = 1'b1;
					state_nxt    = st.more ? ST_SCAN : ST_EMIT;
				end else begin
					cmd.keep_scan = 1'b1;
					state_nxt     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/ctsb_dpath.sv =====
// Datapath of the spine builder: spine memory, cached top entry, counters,
// comparators and the result register. Depends on ctsb_pkg and ctsb_ram.
`default_nettype none

module ctsb_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ctsb_pkg::ctsb_cmd_t                  cmd,
	output      ctsb_pkg::ctsb_status_t               st,
	input  wire logic [ctsb_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic                                s_tlast,
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	output      logic [ctsb_pkg::OUT_DATA_W-1:0]     m_tdata,
	output      logic                                m_tlast,
	output      logic                                m_tuser
);

	import ctsb_pkg::*;

	logic [CNT_W-1:0]       depth_q, next_q;
	logic [VALUE_WIDTH-1:0] key_q, top_key_q, in_key, rd_key;
	logic [ADDR_W-1:0]      top_idx_q, root_q, li_q, rd_idx;
	logic                   last_q, ovf_q, lv_q;

	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_valid_q, out_last_q, out_ovf_q;

	logic [ENTRY_W-1:0]     rd_entry;
	logic [CNT_W-1:0]       below_top;
	logic                   ram_re, ram_we, has_spine;

	logic [IDX_W-1:0]       o_node, o_pi, o_li, o_root;
	logic                   o_pv, o_lv;

	assign in_key    = s_tdata[VALUE_WIDTH-1:0] ^ SIGN_FLIP;
	assign rd_key    = rd_entry[ENTRY_W-1:ADDR_W];
	assign rd_idx    = rd_entry[ADDR_W-1:0];
	assign has_spine = (depth_q != '0);
	assign below_top = depth_q - CNT_W'(2);

	assign st.ovf      = (next_q >= CNT_W'(MAX_NODES)) || (depth_q >= CNT_W'(MAX_NODES));
	assign st.top_ge   = has_spine && (top_key_q >= in_key);
	assign st.more     = (depth_q > CNT_W'(1));
	assign st.scan_gt  = (rd_key > key_q);
	assign st.out_free = !out_valid_q || m_tready;

	assign ram_re = cmd.pop_top || cmd.pop_scan;
	assign ram_we = cmd.emit && !ovf_q;

	ctsb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NODES)
	) u_spine (
		.clk   (clk),
		.we    (ram_we),
		.waddr (depth_q[ADDR_W-1:0]),
		.wdata ({key_q, next_q[ADDR_W-1:0]}),
		.re    (ram_re),
		.raddr (below_top[ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	// result fields, zero where there is no link
	always_comb begin
		o_node = ovf_q ? '0 : next_q[IDX_W-1:0];
		o_pv   = !ovf_q && has_spine;
		o_pi   = o_pv ? top_idx_q : '0;
		o_lv   = !ovf_q && lv_q;
		o_li   = o_lv ? li_q : '0;
		if (ovf_q) begin
			o_root = has_spine ? root_q : '0;
		end else begin
			o_root = has_spine ? root_q : next_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop_top || cmd.pop_scan) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					depth_q <= '0;
					next_q  <= '0;
				end else if (!ovf_q) begin
					depth_q <= depth_q + CNT_W'(1);
					next_q  <= next_q + CNT_W'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= in_key;
			last_q <= s_tlast;
			ovf_q  <= st.ovf;
			lv_q   <= cmd.pop_top;
		end
		if (cmd.pop_top) begin
			li_q <= top_idx_q;
		end
		if (cmd.pop_scan) begin
			li_q <= rd_idx;
		end
		if (cmd.keep_scan) begin
			top_key_q <= rd_key;
			top_idx_q <= rd_idx;
		end
		if (cmd.emit) begin
			out_data_q <= OUT_DATA_W'({o_root, o_li, o_lv, o_pi, o_pv, o_node});
			out_last_q <= last_q;
			out_ovf_q  <= ovf_q;
			if (!ovf_q) begin
				top_key_q <= key_q;
				top_idx_q <= next_q[ADDR_W-1:0];
				if (!has_spine) begin
					root_q <= next_q[ADDR_W-1:0];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

`default_nettype wire

// ===== hdl/cartesian_tree_stack_builder.sv =====
// Min-rooted Cartesian tree builder over a value stream, right-spine stack.
// A request is accepted in ST_IDLE, popped entries are read back from the spine memory
// in ST_SCAN, and the result register is loaded in ST_EMIT; no new request is taken
// before the last one's result is loaded. A result held by the sink stalls the next emit.
// Reset clears spine depth, node counter, sequencer and result valid; spine
// memory contents are left as they are. Depends on ctsb_pkg, ctsb_ctrl, ctsb_dpath.
`default_nettype none

module cartesian_tree_stack_builder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [ctsb_pkg::IN_DATA_W-1:0]  s_tdata,  // value
	input  wire logic                            s_tlast,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [ctsb_pkg::OUT_DATA_W-1:0] m_tdata,  // node_index, parent_valid,
	                                                       // parent_index, left_valid,
	                                                       // left_index, root_index, pad
	output      logic                            m_tlast,
	output      logic                            m_tuser   // overflow
);

	import ctsb_pkg::*;

	ctsb_cmd_t    cmd;
	ctsb_status_t st;

	ctsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ctsb_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== tb/cartesian_tree_stack_builder_tb.sv =====
// Self-checking bench for cartesian_tree_stack_builder: a spine-stack predictor in a
// small scoreboard class, random sequences under varying back-pressure.
// Depends on ctsb_pkg and the block's RTL.
`default_nettype none

module cartesian_tree_stack_builder_tb;
	import ctsb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 1450;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic [IDX_W-1:0] node;
		logic             parent_ok;
		logic [IDX_W-1:0] parent;
		logic             left_ok;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] root;
		logic             ovf;
		logic             lst;
	} tree_link_t;

	typedef enum {VAL_WIDE, VAL_NARROW, VAL_RISING, VAL_FALLING, VAL_EXTREME} value_shape_t;

	class tree_link_board;
		value_t           spine_val[MAX_NODES];
		logic [IDX_W-1:0] spine_idx[MAX_NODES];
		int               depth;
		int               next_node;
		tree_link_t       expected[$];
		int               errors;

		function new();
			depth = 0;
			next_node = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// predict the links for one accepted request
		function void note_request(value_t v, logic lst);
			tree_link_t e;
			e = '0;
			e.lst = lst;
			if (next_node >= MAX_NODES || depth >= MAX_NODES) begin
				e.ovf = 1'b1;
				if (depth > 0)
					e.root = spine_idx[0];
			end else begin
				e.node = IDX_W'(next_node);
				// newest entry pops on >=, older ones only on strictly >
				if (depth > 0 && spine_val[depth-1] >= v) begin
					depth--;
					e.left_ok = 1'b1;
					e.left = spine_idx[depth];
					while (depth > 0 && spine_val[depth-1] > v) begin
						depth--;
						e.left = spine_idx[depth];
					end
				end
				if (depth > 0) begin
					e.parent_ok = 1'b1;
					e.parent = spine_idx[depth-1];
				end
				spine_val[depth] = v;
				spine_idx[depth] = IDX_W'(next_node);
				depth++;
				next_node++;
				e.root = spine_idx[0];
			end
			if (lst) begin
				depth = 0;
				next_node = 0;
			end
			expected.push_back(e);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [OUT_DATA_W-1:0] data, logic user, logic lst);
			tree_link_t e;
			if (expected.size() == 0) begin
				report($sformatf("unexpected result data=%h user=%b last=%b", data, user, lst));
				return;
			end
			e = expected.pop_front();
			if (data[5:0] !== e.node)
				report($sformatf("node_index %0d, want %0d", data[5:0], e.node));
			if (data[6] !== e.parent_ok)
				report($sformatf("parent_valid %b, want %b", data[6], e.parent_ok));
			if (data[12:7] !== e.parent)
				report($sformatf("parent_index %0d, want %0d", data[12:7], e.parent));
			if (data[13] !== e.left_ok)
				report($sformatf("left_valid %b, want %b", data[13], e.left_ok));
			if (data[19:14] !== e.left)
				report($sformatf("left_index %0d, want %0d", data[19:14], e.left));
			if (data[25:20] !== e.root)
				report($sformatf("root_index %0d, want %0d", data[25:20], e.root));
			if (user !== e.ovf)
				report($sformatf("overflow %b, want %b", user, e.ovf));
			if (lst !== e.lst)
				report($sformatf("last %b, want %b", lst, e.lst));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	tree_link_board sb;
	int send_idle = 35;
	int recv_idle = 86;
	int item_count = 0;
	int hold_left = 0;
	bit want_hold = 1'b0;
	int quiet_cycles = 0;

	cartesian_tree_stack_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_item(value_t v, logic lst);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		sb.note_request(v, lst);
		item_count++;
	endtask

	// drop valid and wait until every outstanding request has its result
	task automatic drain_requests();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic value_t pick_value(value_shape_t shape, int pos, int len);
		int top;
		top = (len < MAX_NODES) ? len : MAX_NODES;
		case (shape)
			VAL_WIDE:    return value_t'($urandom);
			VAL_NARROW:  return value_t'(int'($urandom_range(6)) - 3);
			// deep spine, then one random value that may pop most of it
			VAL_RISING:  return (pos == top - 1) ? value_t'($urandom)
			                   : value_t'(pos * 1024 + int'($urandom_range(3)) - 32768);
			VAL_FALLING: return value_t'(int'($urandom_range(3)) - pos * 1024);
			default: begin
				case ($urandom_range(4))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 32'sh0;
					3:       return -32'sh1;
					default: return 32'sh1;
				endcase
			end
		endcase
	endfunction

	task automatic run_sequence(int len, value_shape_t shape);
		for (int pos = 0; pos < len; pos++)
			send_item(pick_value(shape, pos, len), pos == len - 1);
	endtask

	initial begin : stimulus
		int len;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone node, then extremes and ties, then monotone runs
		send_item(32'sh0, 1'b1);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(-32'sh1, 1'b0);
		send_item(32'sh0, 1'b0);
		send_item(32'sh0, 1'b0);
		send_item(32'sh1, 1'b0);
		send_item(-32'sh1, 1'b1);
		send_item(32'sh64, 1'b0);
		send_item(32'sh32, 1'b0);
		send_item(32'sh32, 1'b0);
		send_item(32'sha, 1'b0);
		send_item(-32'sha, 1'b1);
		for (int i = 1; i <= 4; i++)
			send_item(value_t'(i), 1'b0);
		send_item(32'sh0, 1'b1);

		item_count = 0;
		while (item_count < RANDOM_ITEMS) begin
			if (send_idle == 35 && item_count >= RANDOM_ITEMS / 3) begin
				drain_requests();
				send_idle = 86;
				recv_idle = 35;
			end else if (send_idle == 86 && item_count >= 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
				want_hold = 1'b1;
			end
			// some sequences run past capacity so overflow is reached
			if ($urandom_range(11) == 0)
				len = $urandom_range(60, 70);
			else
				len = $urandom_range(1, 20);
			run_sequence(len, value_shape_t'($urandom_range(4)));
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * MAX_NODES + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// result side: check, then choose tready for the next edge
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
		if (want_hold) begin
			want_hold = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
